### hdl/sac_pkg.sv
// Shared types and constants for the set-associative tag store with prefetch.
// Used by the controller, the datapath and the top level.
`default_nettype none
package sac_pkg;

  localparam int unsigned SETS         = 512;
  localparam int unsigned WAYS         = 8;
  localparam int unsigned LINE_BYTES   = 64;
  localparam int unsigned ADDR_BITS    = 48;
  localparam int unsigned MAX_PREFETCH = 4;

  localparam int unsigned OFF_W  = $clog2(LINE_BYTES);
  localparam int unsigned SET_W  = $clog2(SETS);
  localparam int unsigned TAG_W  = ADDR_BITS - OFF_W - SET_W;
  localparam int unsigned WAY_W  = $clog2(WAYS);
  localparam int unsigned AGE_W  = $clog2(WAYS + 1);
  localparam int unsigned LINE_W = $clog2(MAX_PREFETCH + 1);
  localparam int unsigned CMP_W  = SET_W + 2;
  localparam int unsigned CNT_W  = 32;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  // configuration register indexes
  localparam logic CFG_REPL_MODE = 1'b0;
  localparam logic CFG_PF_DEPTH  = 1'b1;

  // replacement modes
  localparam logic MODE_LRU    = 1'b0;
  localparam logic MODE_RANDOM = 1'b1;

  typedef struct packed {
    logic [WAYS-1:0][TAG_W-1:0] tag;
    logic [WAYS-1:0][AGE_W-1:0] age;
    logic [WAYS-1:0]            valid;
  } row_t;

  localparam int unsigned ROW_W = $bits(row_t);

  typedef struct packed {
    logic              clear;
    logic [SET_W-1:0]  clr_addr;
    logic              accept;
    logic              lookup;
    logic [LINE_W-1:0] line;
    logic [LINE_W-1:0] line_nxt;
    logic              finish;
  } cmd_t;

  typedef struct packed {
    logic more;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

### hdl/sac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hdl/sac_ctrl.sv
// Sequencer: clearing pass, accept, per-set lookup steps, result hand-off.
// Depends on sac_pkg.
`default_nettype none
module sac_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire sac_pkg::stat_t stat_i,
  output      sac_pkg::cmd_t  cmd_o
);
  import sac_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [SET_W-1:0]  clr_q, clr_d;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clear    = (state_q == ST_CLEAR);
    cmd_o.clr_addr = clr_q;
    cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.lookup   = (state_q == ST_LOOKUP);
    cmd_o.line     = line_q;
    cmd_o.line_nxt = line_q + LINE_W'(1);
    cmd_o.finish   = (state_q == ST_FINISH) && !stat_i.out_busy;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    line_d  = line_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + SET_W'(1);
        if (clr_q == SET_W'(SETS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          line_d  = '0;
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (stat_i.more) line_d = line_q + LINE_W'(1);
        else state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!stat_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      line_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      line_q  <= line_d;
      clr_q   <= clr_d;
    end
  end

  a_accept_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == ST_LOOKUP && line_q == '0)
    else $error("accept did not start lookup");
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_q <= LINE_W'(MAX_PREFETCH))
    else $error("prefetch line counter out of range");
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !in_ready_o)
    else $error("ready during clearing pass");
endmodule
`default_nettype wire

### hdl/sac_dp.sv
// Datapath: set RAM, hit/victim/age logic, LFSR, counters, config and result registers.
// Depends on sac_pkg and sac_ram.
`default_nettype none
module sac_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire sac_pkg::cmd_t                 cmd_i,
  output      sac_pkg::stat_t                stat_o,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [2:0]                    cfg_data_i,
  input  wire logic                          is_write_i,
  input  wire logic [sac_pkg::ADDR_BITS-1:0] address_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          hit_o,
  output      logic [2:0]                    way_used_o,
  output      logic [2:0]                    prefetches_issued_o,
  output      logic [31:0]                   read_hit_total_o,
  output      logic [31:0]                   read_miss_total_o,
  output      logic [31:0]                   write_hit_total_o,
  output      logic [31:0]                   write_miss_total_o,
  output      logic [31:0]                   prefetch_total_o
);
  import sac_pkg::*;

  logic              mode_q;
  logic [2:0]        depth_cfg_q;
  logic [2:0]        depth_q;
  logic              wr_q;
  logic [SET_W-1:0]  set_q;
  logic [TAG_W-1:0]  tag_q;
  logic [15:0]       lfsr_q, lfsr_nx;
  logic [CNT_W-1:0]  rh_q, rm_q, wh_q, wm_q, pf_q;
  logic              hit_q;
  logic [WAY_W-1:0]  way_q;
  logic [2:0]        issued_q;
  logic              out_valid_q;

  logic              ram_we;
  logic [SET_W-1:0]  ram_waddr, ram_raddr;
  logic [ROW_W-1:0]  ram_wdata, ram_rdata;
  row_t              row, new_row;

  logic [WAYS-1:0]   match;
  logic              hit_any, any_inv, is_prim, do_write, do_touch, adv_lfsr;
  logic [WAY_W-1:0]  hit_way, inv_way, lru_way, vict, way_sel;
  logic [AGE_W-1:0]  best_age, cur_age;
  logic [CMP_W-1:0]  pf_sum;

  sac_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign row = row_t'(ram_rdata);

  // next prefetch set is probed only while line_nxt <= depth and set + line_nxt + depth <= SETS
  assign pf_sum = CMP_W'(set_q) + CMP_W'(cmd_i.line_nxt) + CMP_W'(depth_q);
  assign stat_o.more = (3'(cmd_i.line_nxt) <= depth_q) && (pf_sum <= CMP_W'(SETS));
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

  assign ram_raddr = cmd_i.accept ? address_i[OFF_W +: SET_W]
                                  : set_q + SET_W'(cmd_i.line_nxt);

  always_comb begin
    lfsr_nx = lfsr_q >> 1;
    if (lfsr_q[0]) lfsr_nx = lfsr_nx ^ LFSR_TAPS;
  end

  always_comb begin
    match    = '0;
    hit_way  = '0;
    inv_way  = '0;
    hit_any  = 1'b0;
    any_inv  = 1'b0;
    lru_way  = '0;
    best_age = '0;
    for (int i = 0; i < WAYS; i++) begin
      match[i] = row.valid[i] && (row.tag[i] == tag_q);
    end
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!row.valid[i]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(i);
      end
    end
    // oldest way, ties go to the highest index
    for (int i = 0; i < WAYS; i++) begin
      if (row.age[i] >= best_age) begin
        best_age = row.age[i];
        lru_way  = WAY_W'(i);
      end
    end
  end

  always_comb begin
    is_prim  = (cmd_i.line == '0);
    adv_lfsr = !hit_any && !any_inv && (mode_q == MODE_RANDOM);
    priority if (any_inv)            vict = inv_way;
    else if (mode_q == MODE_RANDOM)  vict = lfsr_nx[WAY_W-1:0];
    else                             vict = lru_way;
    way_sel  = hit_any ? hit_way : vict;
    do_write = is_prim || !hit_any;
    do_touch = (mode_q == MODE_LRU) && do_write;
    cur_age  = row.age[way_sel];
    new_row  = row;
    if (do_touch) begin
      for (int i = 0; i < WAYS; i++) begin
        if (WAY_W'(i) == way_sel) begin
          new_row.age[i] = AGE_W'(1);
        end else if (row.valid[i] && (cur_age == '0 || row.age[i] < cur_age)
                     && row.age[i] < AGE_W'(WAYS)) begin
          new_row.age[i] = row.age[i] + AGE_W'(1);
        end
      end
    end
    if (!hit_any) begin
      new_row.tag[way_sel]   = tag_q;
      new_row.valid[way_sel] = 1'b1;
    end
  end

  assign ram_we    = cmd_i.clear || (cmd_i.lookup && do_write);
  assign ram_waddr = cmd_i.clear ? cmd_i.clr_addr : set_q + SET_W'(cmd_i.line);
  assign ram_wdata = cmd_i.clear ? '0 : ROW_W'(new_row);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      wr_q  <= is_write_i;
      set_q <= address_i[OFF_W +: SET_W];
      tag_q <= address_i[OFF_W + SET_W +: TAG_W];
    end
    if (cmd_i.lookup && is_prim) begin
      hit_q <= hit_any;
      way_q <= way_sel;
    end
    if (cmd_i.finish) begin
      hit_o               <= hit_q;
      way_used_o          <= 3'(way_q);
      prefetches_issued_o <= issued_q;
      read_hit_total_o    <= rh_q;
      read_miss_total_o   <= rm_q;
      write_hit_total_o   <= wh_q;
      write_miss_total_o  <= wm_q;
      prefetch_total_o    <= pf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_LRU;
      depth_cfg_q <= 3'd1;
      depth_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      rh_q        <= '0;
      rm_q        <= '0;
      wh_q        <= '0;
      wm_q        <= '0;
      pf_q        <= '0;
      issued_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_REPL_MODE: mode_q      <= cfg_data_i[0];
          CFG_PF_DEPTH:  depth_cfg_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        depth_q <= (depth_cfg_q > 3'(MAX_PREFETCH)) ? 3'(MAX_PREFETCH) : depth_cfg_q;
      end
      if (cmd_i.accept) issued_q <= '0;
      if (cmd_i.lookup) begin
        if (adv_lfsr) lfsr_q <= lfsr_nx;
        if (is_prim) begin
          priority case ({wr_q, hit_any})
            2'b01:   rh_q <= rh_q + 1'b1;
            2'b00:   rm_q <= rm_q + 1'b1;
            2'b11:   wh_q <= wh_q + 1'b1;
            default: wm_q <= wm_q + 1'b1;
          endcase
        end else if (!hit_any) begin
          pf_q     <= pf_q + 1'b1;
          issued_q <= issued_q + 3'd1;
        end
      end
      if (cmd_i.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_lfsr_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lfsr_q != '0)
    else $error("victim LFSR reached zero");
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && !out_ready_i))
    else $error("result overwritten before taken");
  a_issued_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issued_q <= depth_q || cmd_i.accept)
    else $error("more prefetch fills than depth");
endmodule
`default_nettype wire

### hdl/set_assoc_cache_lru_next_line_prefetch_core.sv
// Tag store of an 8-way, 512-set cache (64-byte lines, 48-bit addresses) with LRU or
// pseudo-random replacement and a next-N-line prefetcher. After reset a clearing pass
// zeroes all 512 sets of the set RAM, during which no item is taken. For each item, P
// (0 to 4) is the number of prefetched sets probed: the set RAM does one read-modify-write
// per set, the read for the next set overlapping the write of the current one. Depends on
// sac_pkg, sac_ctrl, sac_dp and sac_ram.
`default_nettype none
module set_assoc_cache_lru_next_line_prefetch_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [2:0]                    cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          is_write_i,
  input  wire logic [sac_pkg::ADDR_BITS-1:0] address_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          hit_o,
  output      logic [2:0]                    way_used_o,
  output      logic [2:0]                    prefetches_issued_o,
  output      logic [31:0]                   read_hit_total_o,
  output      logic [31:0]                   read_miss_total_o,
  output      logic [31:0]                   write_hit_total_o,
  output      logic [31:0]                   write_miss_total_o,
  output      logic [31:0]                   prefetch_total_o
);
  import sac_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  sac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sac_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .is_write_i          (is_write_i),
    .address_i           (address_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .hit_o               (hit_o),
    .way_used_o          (way_used_o),
    .prefetches_issued_o (prefetches_issued_o),
    .read_hit_total_o    (read_hit_total_o),
    .read_miss_total_o   (read_miss_total_o),
    .write_hit_total_o   (write_hit_total_o),
    .write_miss_total_o  (write_miss_total_o),
    .prefetch_total_o    (prefetch_total_o)
  );
endmodule
`default_nettype wire
